// ===== rtl/dgca_pkg.sv =====
// Package for the data group CRC-16 assembler.
// Holds widths, CRC constants, the result struct and the byte-wide CRC update.
// No dependencies.
`default_nettype none

package dgca_pkg;

    localparam int LenBits = 14;

    localparam logic [15:0] CrcPoly = 16'h1021;
    localparam logic [15:0] CrcInit = 16'hFFFF;

    typedef logic [LenBits-1:0] t_len;

    localparam t_len CrcBytes = t_len'(2);

    localparam int CfgDataBits = 32;
    localparam int CfgAddrBits = 2;

    typedef struct packed {
        logic       accepted;
        logic [7:0] byte_out;
        t_len       byte_index;
        logic       group_done;
        logic       crc_match;
    } t_result;

    // MSB-first CRC-16 update over one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CrcPoly;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dgca_core.sv =====
// Group state and per-byte result logic of the data group CRC-16 assembler.
// Depends on dgca_pkg.
`default_nettype none

module dgca_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_take,
    input  wire logic             i_cmd,
    input  wire logic [7:0]       i_data_byte,
    input  wire dgca_pkg::t_len   i_group_length,
    output dgca_pkg::t_result     o_result
);
    import dgca_pkg::*;

    t_len        r_count, n_count;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_rcv, n_rcv;

    logic        full;
    logic        is_crc_data;
    logic        is_last;
    logic        long_enough;

    assign long_enough = (i_group_length >= CrcBytes);
    assign full        = (r_count >= i_group_length);
    assign is_crc_data = long_enough && (r_count < (i_group_length - CrcBytes));
    assign is_last     = (({1'b0, r_count} + (LenBits+1)'(1)) == {1'b0, i_group_length});

    always_comb begin
        n_count  = r_count;
        n_crc    = r_crc;
        n_rcv    = r_rcv;
        o_result = '0;
        if (i_cmd) begin
            n_count = '0;
            n_crc   = CrcInit;
            n_rcv   = '0;
        end else if (!full) begin
            if (is_crc_data) begin
                n_crc = crc16_byte(r_crc, i_data_byte);
            end else begin
                n_rcv = {r_rcv[7:0], i_data_byte};
            end
            n_count             = r_count + t_len'(1);
            o_result.accepted   = 1'b1;
            o_result.byte_out   = i_data_byte;
            o_result.byte_index = r_count;
            o_result.group_done = is_last;
            o_result.crc_match  = is_last && long_enough && (n_rcv == (n_crc ^ CrcInit));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= CrcInit;
            r_rcv   <= '0;
        end else if (i_take) begin
            r_count <= n_count;
            r_crc   <= n_crc;
            r_rcv   <= n_rcv;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dgca_out_reg.sv =====
// Output register of the data group CRC-16 assembler: holds one result
// transaction until the downstream side takes it. Depends on dgca_pkg.
`default_nettype none

module dgca_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire dgca_pkg::t_result i_result,
    input  wire logic              i_stall,
    output logic                   o_valid,
    output dgca_pkg::t_result      o_result
);
    import dgca_pkg::*;

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== rtl/data_group_crc16_assembler_top.sv =====
// Top level of the data group CRC-16 assembler: APB length register,
// group state core and output register. Depends on dgca_pkg, dgca_core, dgca_out_reg.
//
// The block takes one transaction per clock while o_stall is low: either a restart
// command or a data byte of a group whose byte count is set by the group_length
// register. Every input transaction yields exactly one result transaction in the
// following cycle, through a single output register; with i_stall low the block
// sustains one transaction per cycle, and o_stall is high only while a result
// sits in the output register and the downstream side stalls. Data bytes are
// accepted while fewer than group_length bytes have been taken; each accepted
// byte is passed through with its index for storage downstream. All bytes but
// the last two feed a CRC-16 (poly 0x1021, MSB first, init 0xFFFF, output
// inverted), computed combinationally by a one-byte XOR network; the last
// two bytes are the received CRC, high byte first. The result for the final
// byte carries group_done and crc_match. Surplus bytes and restarts return a
// result with all fields zero. A group shorter than two bytes never matches.
// Write group_length (register 0, byte address 0) only while the block is idle.
`default_nettype none

module data_group_crc16_assembler_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input channel
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic                              i_cmd,
    input  wire logic [7:0]                        i_data_byte,
    // output channel
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic                                   o_accepted,
    output logic [7:0]                             o_byte_out,
    output logic [dgca_pkg::LenBits-1:0]           o_byte_index,
    output logic                                   o_group_done,
    output logic                                   o_crc_match,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [dgca_pkg::CfgAddrBits-1:0]  paddr,
    input  wire logic [dgca_pkg::CfgDataBits-1:0]  pwdata,
    output logic [dgca_pkg::CfgDataBits-1:0]       prdata,
    output logic                                   pready
);
    import dgca_pkg::*;

    t_len    r_group_length;
    logic    take;
    logic    cfg_write;
    t_result core_result;
    t_result out_result;

    // Only one register: every address in its word decodes to it.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = CfgDataBits'({paddr[0] & 1'b0, r_group_length});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_length <= '0;
        end else if (cfg_write) begin
            r_group_length <= pwdata[LenBits-1:0];
        end
    end

    // Hold the input while the output register is full and stalled.
    assign o_stall = o_valid && i_stall;
    assign take    = i_valid && !o_stall;

    dgca_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take),
        .i_cmd          (i_cmd),
        .i_data_byte    (i_data_byte),
        .i_group_length (r_group_length),
        .o_result       (core_result)
    );

    dgca_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take),
        .i_result (core_result),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_accepted   = out_result.accepted;
    assign o_byte_out   = out_result.byte_out;
    assign o_byte_index = out_result.byte_index;
    assign o_group_done = out_result.group_done;
    assign o_crc_match  = out_result.crc_match;

endmodule

`default_nettype wire

// ===== rtl/dgca_checker.sv =====
// Port-level checker for the data group CRC-16 assembler, bound to the top.
// Depends on dgca_pkg and data_group_crc16_assembler_top.
`default_nettype none

module dgca_checker (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    o_valid,
    input wire logic                    i_stall,
    input wire logic                    o_accepted,
    input wire logic [7:0]              o_byte_out,
    input wire logic [dgca_pkg::LenBits-1:0] o_byte_index,
    input wire logic                    o_group_done,
    input wire logic                    o_crc_match
);
    import dgca_pkg::*;

    // a stalled result transaction holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_byte_out) && $stable(o_byte_index)
            && $stable(o_accepted) && $stable(o_group_done) && $stable(o_crc_match))
        else $error("stalled result changed");

    a_match_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_crc_match |-> o_group_done)
        else $error("crc_match without group_done");

    a_done_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_group_done |-> o_accepted)
        else $error("group_done on refused byte");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_accepted |-> (o_byte_out == 8'h00) && (o_byte_index == '0))
        else $error("refused result carries data");

endmodule

bind data_group_crc16_assembler_top dgca_checker u_dgca_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_accepted   (o_accepted),
    .o_byte_out   (o_byte_out),
    .o_byte_index (o_byte_index),
    .o_group_done (o_group_done),
    .o_crc_match  (o_crc_match)
);

`default_nettype wire
